@@ rtl/pld_pkg.sv @@
// pixel line downscaler: shared types and constants
// no dependencies; used by the stream interfaces and the core
`default_nettype none

package pld_pkg;

  localparam int PIXEL_W    = 16;
  localparam int POS_W      = 10;
  localparam int TWIDTH_W   = 11;
  localparam int SWIDTH_W   = 12;
  localparam int MODE_W     = 2;
  localparam int ERR_W      = 13;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  typedef logic [PIXEL_W-1:0]  pixel_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [TWIDTH_W-1:0] twidth_t;
  typedef logic [SWIDTH_W-1:0] swidth_t;
  typedef logic [MODE_W-1:0]   mode_t;

  // register indexes on the configuration port
  localparam logic [1:0] REG_TARGET_WIDTH = 2'd0;
  localparam logic [1:0] REG_SOURCE_WIDTH = 2'd1;
  localparam logic [1:0] REG_MODE         = 2'd2;
  localparam logic [1:0] REG_BLEND_MASK   = 2'd3;

  // mode codes; the unused code behaves as forward
  localparam mode_t MODE_FORWARD  = 2'd0;
  localparam mode_t MODE_REVERSED = 2'd1;
  localparam mode_t MODE_BLEND    = 2'd2;

  localparam twidth_t RST_TARGET_WIDTH = 11'd176;
  localparam swidth_t RST_SOURCE_WIDTH = 12'd320;
  localparam mode_t   RST_MODE         = MODE_FORWARD;
  localparam pixel_t  RST_BLEND_MASK   = 16'hf7de;

  // saturation limits of the error term, 13-bit signed
  localparam logic signed [ERR_W:0] ERR_MIN = -14'sd4096;
  localparam logic signed [ERR_W:0] ERR_MAX = 14'sd4095;

endpackage

`default_nettype wire

@@ rtl/pld_stream_if.sv @@
// pixel line downscaler: valid/ready stream interfaces for source items and results
// depends on pld_pkg
`default_nettype none

interface pld_in_if;
  import pld_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t source_pixel;
  pixel_t background_pixel;

  modport source (output valid, output source_pixel, output background_pixel, input ready);
  modport sink   (input valid, input source_pixel, input background_pixel, output ready);
endinterface

interface pld_out_if;
  import pld_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t output_pixel;
  pos_t   output_position;
  logic   last_of_line;

  modport source (output valid, output output_pixel, output output_position,
                  output last_of_line, input ready);
  modport sink   (input valid, input output_pixel, input output_position,
                  input last_of_line, output ready);
endinterface

`default_nettype wire

@@ rtl/pixel_line_downscaler_core.sv @@
// pixel line downscaler top level: input register, error-term step, result register
// depends on pld_pkg and the stream interfaces in pld_stream_if.sv
`default_nettype none

// Shrinks a scanline of 16-bit pixels from source_width to target_width with a
// Bresenham error term. One source pixel is taken per cycle, back to back, unless
// the receiver stalls; each either yields one output pixel or is held to be
// averaged with the next one. Items pass the input register, then the result
// register. Throughput is one item per clock unless the receiver stalls, set by
// the error term, held pixel and output count update in the compute stage. A line
// ends after max(target_width,1) outputs, at most MAX_LINE_WIDTH; last_of_line marks the last.
// Registers at byte addresses 0x0 target_width, 0x4 source_width, 0x8 mode,
// 0xC blend_mask; a write takes effect at once and keeps the line state, and is
// to be made while no transaction is in flight.
module pixel_line_downscaler_core #(
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  pld_in_if.sink                               in_if,
  pld_out_if.source                            out_if,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [pld_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [pld_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [pld_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                 pready
);
  import pld_pkg::*;

  localparam logic [TWIDTH_W+1:0] MAX_W = (TWIDTH_W+2)'(MAX_LINE_WIDTH);

  // configuration registers
  twidth_t target_width_r;
  swidth_t source_width_r;
  mode_t   mode_r;
  pixel_t  blend_mask_r;

  // input register
  logic    s1_valid_r;
  pixel_t  s1_src_r;
  pixel_t  s1_bg_r;

  // line state
  logic signed [ERR_W-1:0] err_r, err_nxt;
  pixel_t                  held_r, held_nxt;
  logic                    holding_r, holding_nxt;
  twidth_t                 done_r, done_nxt;

  // result register
  logic    out_valid_r;
  pixel_t  out_pixel_r;
  pos_t    out_pos_r;
  logic    out_last_r;

  logic    cfg_wr;
  logic    out_free;
  logic    s1_adv;
  logic    in_acc;

  twidth_t                 tw_nz;
  twidth_t                 eff;
  logic signed [ERR_W:0]   diff_raw;
  swidth_t                 diff;
  logic signed [ERR_W:0]   err_sub;
  logic signed [ERR_W:0]   err_add;
  logic signed [ERR_W-1:0] err_dec;
  logic                    emit;
  logic [PIXEL_W:0]        avg_sum;
  logic [PIXEL_W:0]        blend_sum;
  pixel_t                  pix_base;
  pixel_t                  pix;
  twidth_t                 mirror;
  pos_t                    pos;
  logic [TWIDTH_W:0]       done_inc;
  logic                    last;

  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [ERR_W:0] v);
    logic signed [ERR_W-1:0] r;
    if (v < ERR_MIN) begin
      r = ERR_MIN[ERR_W-1:0];
    end else if (v > ERR_MAX) begin
      r = ERR_MAX[ERR_W-1:0];
    end else begin
      r = v[ERR_W-1:0];
    end
    return r;
  endfunction

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_width_r <= RST_TARGET_WIDTH;
      source_width_r <= RST_SOURCE_WIDTH;
      mode_r         <= RST_MODE;
      blend_mask_r   <= RST_BLEND_MASK;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_TARGET_WIDTH: target_width_r <= pwdata[TWIDTH_W-1:0];
        REG_SOURCE_WIDTH: source_width_r <= pwdata[SWIDTH_W-1:0];
        REG_MODE:         mode_r         <= pwdata[MODE_W-1:0];
        REG_BLEND_MASK:   blend_mask_r   <= pwdata[PIXEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TARGET_WIDTH: prdata = {{(CFG_DATA_W-TWIDTH_W){1'b0}}, target_width_r};
      REG_SOURCE_WIDTH: prdata = {{(CFG_DATA_W-SWIDTH_W){1'b0}}, source_width_r};
      REG_MODE:         prdata = {{(CFG_DATA_W-MODE_W){1'b0}}, mode_r};
      REG_BLEND_MASK:   prdata = {{(CFG_DATA_W-PIXEL_W){1'b0}}, blend_mask_r};
      default:          prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  assign out_free    = !out_valid_r || out_if.ready;
  assign s1_adv      = s1_valid_r && out_free;
  assign in_if.ready = !s1_valid_r || out_free;
  assign in_acc      = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_src_r <= in_if.source_pixel;
      s1_bg_r  <= in_if.background_pixel;
    end
  end

  // ---------------- error-term step ----------------
  always_comb begin
    tw_nz = (target_width_r == '0) ? TWIDTH_W'(1) : target_width_r;
    eff   = ({2'b00, tw_nz} > MAX_W) ? MAX_W[TWIDTH_W-1:0] : tw_nz;

    // width difference, clamped at zero
    diff_raw = $signed({2'b00, source_width_r}) - $signed({3'b000, eff});
    diff     = diff_raw[ERR_W] ? '0 : diff_raw[SWIDTH_W-1:0];

    err_sub = $signed({err_r[ERR_W-1], err_r}) - $signed({2'b00, diff});
    err_add = $signed({err_r[ERR_W-1], err_r}) + $signed({3'b000, eff});
    err_dec = sat_err(err_sub);

    avg_sum  = {1'b0, held_r} + {1'b0, s1_src_r};
    pix_base = holding_r ? avg_sum[PIXEL_W:1] : s1_src_r;
    emit     = holding_r || !err_dec[ERR_W-1];

    blend_sum = {1'b0, pix_base & blend_mask_r} + {1'b0, s1_bg_r & blend_mask_r};
    pix       = (mode_r == MODE_BLEND) ? blend_sum[PIXEL_W:1] : pix_base;

    mirror = eff - TWIDTH_W'(1) - done_r;
    pos    = ((mode_r == MODE_REVERSED) && (done_r < eff)) ? mirror[POS_W-1:0]
                                                           : done_r[POS_W-1:0];

    done_inc = {1'b0, done_r} + (TWIDTH_W+1)'(1);
    last     = done_inc >= {1'b0, eff};

    err_nxt     = err_r;
    held_nxt    = held_r;
    holding_nxt = holding_r;
    done_nxt    = done_r;
    if (s1_adv) begin
      if (!holding_r) begin
        err_nxt = err_dec;
        if (!emit) begin
          held_nxt    = s1_src_r;
          holding_nxt = 1'b1;
        end
      end else begin
        err_nxt     = sat_err(err_add);
        holding_nxt = 1'b0;
      end
      if (emit) begin
        if (last) begin
          err_nxt     = '0;
          held_nxt    = '0;
          holding_nxt = 1'b0;
          done_nxt    = '0;
        end else begin
          done_nxt = done_inc[TWIDTH_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r     <= '0;
      held_r    <= '0;
      holding_r <= 1'b0;
      done_r    <= '0;
    end else begin
      err_r     <= err_nxt;
      held_r    <= held_nxt;
      holding_r <= holding_nxt;
      done_r    <= done_nxt;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_pixel_r <= pix;
      out_pos_r   <= pos;
      out_last_r  <= last;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.output_pixel    = out_pixel_r;
  assign out_if.output_position = out_pos_r;
  assign out_if.last_of_line    = out_last_r;

`ifndef ASSERT_OFF
  // a held first pixel only exists while the error term is negative
  a_hold_neg: assert property (@(posedge clk) disable iff (!rst_n)
    holding_r |-> err_r[ERR_W-1])
    else $error("pixel held with non-negative error term");

  // the final transaction of a line leaves the line state cleared
  a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && emit && last) |=> (done_r == '0 && !holding_r && err_r == '0))
    else $error("line state not cleared after last output");

  // an item that yields nothing must leave a pixel held
  a_hold_set: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !emit) |=> holding_r)
    else $error("consumed item produced neither result nor held pixel");

  // a result only appears from an emitting step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv && emit))
    else $error("result valid without an emitting step");
`endif

endmodule

`default_nettype wire

@@ dv/tb_pixel_line_downscaler_core.sv @@
// testbench for pixel_line_downscaler_core: random and directed scanlines, checked against
// a cycle-free line model kept in step with every accepted source transaction
// depends on pld_pkg, pld_stream_if.sv and the core rtl
`timescale 1ns / 1ps

module tb_pixel_line_downscaler_core;
  import pld_pkg::*;

  localparam int    LINE_MAX      = 1024;
  localparam int    SETTLE_CYCLES = 8;
  localparam int    CYCLE_LIMIT   = 200000;
  localparam int    REPORT_MAX    = 10;
  localparam mode_t MODE_UNUSED   = 2'd3;

  typedef struct packed {
    pixel_t pixel;
    pos_t   position;
    logic   last;
  } line_result_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  pld_in_if  in_if();
  pld_out_if out_if();

  pixel_line_downscaler_core #(.MAX_LINE_WIDTH(LINE_MAX)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  // register copies and line state of the model, at reset values
  twidth_t set_target = RST_TARGET_WIDTH;
  swidth_t set_source = RST_SOURCE_WIDTH;
  mode_t   set_mode   = RST_MODE;
  pixel_t  set_mask   = RST_BLEND_MASK;
  int      line_err   = 0;
  pixel_t  line_held  = '0;
  bit      line_holding = 1'b0;
  twidth_t line_count = '0;
  int      lines_finished = 0;

  line_result_t expected_results[$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int holdoff_left = 0;
  int mismatches = 0;
  int cycle_count = 0;

  function automatic int clamp_err(int v);
    if (v < -4096) return -4096;
    if (v > 4095) return 4095;
    return v;
  endfunction

  // one accepted source transaction: update the line state, queue any output pixel
  function automatic void shrink_step(pixel_t src, pixel_t bg);
    int           eff;
    int           diff;
    int           cnt;
    logic [16:0]  sum;
    pixel_t       pix;
    int           pos;
    line_result_t res;
    eff = (set_target == 0) ? 1 : int'(set_target);
    if (eff > LINE_MAX) eff = LINE_MAX;
    diff = int'(set_source) - eff;
    if (diff < 0) diff = 0;
    if (!line_holding) begin
      line_err = clamp_err(line_err - diff);
      if (line_err < 0) begin
        line_held = src;
        line_holding = 1'b1;
        return;
      end
      pix = src;
    end else begin
      sum = line_held + src;
      pix = sum[16:1];
      line_err = clamp_err(line_err + eff);
      line_holding = 1'b0;
    end
    if (set_mode == MODE_BLEND) begin
      sum = (pix & set_mask) + (bg & set_mask);
      pix = sum[16:1];
    end
    cnt = int'(line_count);
    if (set_mode == MODE_REVERSED && cnt < eff) pos = eff - 1 - cnt;
    else pos = cnt;
    res.pixel = pix;
    res.position = pos[POS_W-1:0];
    res.last = (cnt + 1 >= eff);
    expected_results.push_back(res);
    if (res.last) begin
      line_count = '0;
      line_err = 0;
      line_holding = 1'b0;
      line_held = '0;
      lines_finished++;
    end else begin
      line_count = line_count + 1'b1;
    end
  endfunction

  // receiver: random stalls, or a long hold-off while holdoff_left runs down
  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      out_if.ready <= 1'b0;
      holdoff_left = holdoff_left - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    line_result_t want;
    line_result_t got;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.pixel = out_if.output_pixel;
      got.position = out_if.output_position;
      got.last = out_if.last_of_line;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: output transaction with none expected: pixel %h pos %0d last %b",
                   $time, got.pixel, got.position, got.last);
      end else begin
        want = expected_results.pop_front();
        if (got.pixel !== want.pixel || got.position !== want.position ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: mismatch: pixel %h/%h pos %0d/%0d last %b/%b (expected/actual)",
                     $time, want.pixel, got.pixel, want.position, got.position,
                     want.last, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_pixel(pixel_t src, pixel_t bg);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      in_if.source_pixel <= $urandom_range(16'hffff);
      in_if.background_pixel <= $urandom_range(16'hffff);
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.source_pixel <= src;
    in_if.background_pixel <= bg;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    shrink_step(src, bg);
  endtask

  task automatic send_random_pixel();
    send_pixel($urandom_range(16'hffff), $urandom_range(16'hffff));
  endtask

  // stop offering, let every pending output drain; a held pixel stays held in the core
  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_TARGET_WIDTH: set_target = value[TWIDTH_W-1:0];
      REG_SOURCE_WIDTH: set_source = value[SWIDTH_W-1:0];
      REG_MODE:         set_mode   = value[MODE_W-1:0];
      REG_BLEND_MASK:   set_mask   = value[PIXEL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apply_setting(twidth_t tw, swidth_t sw, mode_t md, pixel_t msk);
    settle();
    write_register(REG_TARGET_WIDTH, tw);
    write_register(REG_SOURCE_WIDTH, sw);
    write_register(REG_MODE, md);
    write_register(REG_BLEND_MASK, msk);
  endtask

  task automatic apply_random_setting();
    twidth_t tw;
    swidth_t sw;
    pixel_t  msk;
    if ($urandom_range(99) < 85) begin
      tw = $urandom_range(1, 12);
    end else begin
      case ($urandom_range(3))
        0: tw = '0;
        1: tw = LINE_MAX;
        2: tw = '1;
        default: tw = $urandom_range(13, 2047);
      endcase
    end
    if ($urandom_range(99) < 80) begin
      sw = $urandom_range(0, 40);
    end else begin
      case ($urandom_range(2))
        0: sw = '0;
        1: sw = '1;
        default: sw = $urandom_range(0, 4095);
      endcase
    end
    case ($urandom_range(3))
      0: msk = '1;
      1: msk = '0;
      default: msk = $urandom_range(16'hffff);
    endcase
    apply_setting(tw, sw, $urandom_range(MODE_UNUSED), msk);
  endtask

  // reset register values, pixel words at their extremes
  task automatic test_reset_values();
    send_pixel(16'h0000, 16'hffff);
    send_pixel(16'hffff, 16'h0000);
    send_pixel(16'h5555, 16'haaaa);
    send_pixel(16'haaaa, 16'h5555);
  endtask

  task automatic test_special_widths();
    // zero target acts as a one-pixel line
    apply_setting('0, 3, MODE_FORWARD, RST_BLEND_MASK);
    repeat (2) send_random_pixel();
    // source narrower than target: no averaging, target clamps to the line maximum
    apply_setting('1, '0, MODE_FORWARD, RST_BLEND_MASK);
    repeat (2) send_random_pixel();
    // shrink the target mid-line, count already past it, reversed positions
    apply_setting(2, '0, MODE_REVERSED, RST_BLEND_MASK);
    send_random_pixel();
    // huge width difference drives the error term into saturation
    apply_setting(2, '1, MODE_FORWARD, RST_BLEND_MASK);
    repeat (6) send_random_pixel();
    // blend with full and empty masks
    apply_setting(2, 3, MODE_BLEND, 16'hffff);
    send_pixel(16'hffff, 16'h0000);
    send_pixel(16'hffff, 16'hffff);
    send_pixel(16'h0000, 16'hffff);
    apply_setting(1, 1, MODE_BLEND, 16'h0000);
    send_pixel(16'hffff, 16'hffff);
    // unused mode code behaves as forward
    apply_setting(2, 2, MODE_UNUSED, 16'hffff);
    repeat (2) send_random_pixel();
    apply_setting(3, 4, MODE_REVERSED, RST_BLEND_MASK);
    repeat (4) send_random_pixel();
  endtask

  // mostly whole lines with random content, now and then cut short mid-line
  task automatic test_random_lines(int n_items);
    int sent;
    int seg;
    int seg_cap;
    int line_goal;
    sent = 0;
    while (sent < n_items) begin
      apply_random_setting();
      line_goal = lines_finished + $urandom_range(1, 3);
      seg_cap = ($urandom_range(99) < 15) ? $urandom_range(1, 20) : 150;
      seg = 0;
      while (lines_finished < line_goal && seg < seg_cap) begin
        send_random_pixel();
        seg++;
      end
      sent += seg;
    end
    settle();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_receiver_holdoff();
    apply_setting(16, 20, MODE_BLEND, $urandom_range(16'hffff));
    @(posedge clk);
    holdoff_left = 300;
    repeat (150) send_random_pixel();
    settle();
  endtask

  // one full line at the maximum width, mirrored positions down to zero
  task automatic test_widest_line();
    int line_goal;
    apply_setting('1, $urandom_range(1024, 1200), MODE_REVERSED, $urandom_range(16'hffff));
    line_goal = lines_finished + 1;
    while (lines_finished < line_goal) send_random_pixel();
    settle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.source_pixel = '0;
    in_if.background_pixel = '0;
    out_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    idle_pct = 8;
    stall_pct = 82;
    test_reset_values();
    test_special_widths();
    test_random_lines(250);

    idle_pct = 82;
    stall_pct = 8;
    test_random_lines(200);

    idle_pct = 0;
    stall_pct = 0;
    test_receiver_holdoff();
    test_widest_line();
    test_random_lines(100);

    settle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
